@@ rtl/core/cocc_pkg.sv @@
// Package for the circle obstacle collision checker: item types, codes and constants.
// It has no dependencies. The divider, the top level and the testbench use it.
package cocc_pkg;

  localparam int MAX_OBSTACLES = 64;
  localparam int COORD_WIDTH   = 16;
  localparam int IDX_W         = $clog2(MAX_OBSTACLES);
  localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
  localparam int RAD_W         = 15;
  localparam int NS_W          = 12;
  localparam int ENTRY_W       = 2 * COORD_WIDTH + RAD_W;
  localparam int DIFF_W        = COORD_WIDTH + 1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_POINT = 2'd2,
    ACT_SEG   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_FULL  = 2'd2,
    ST_SPARE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]                    action;
    logic signed [COORD_WIDTH-1:0] x_a;
    logic signed [COORD_WIDTH-1:0] y_a;
    logic signed [COORD_WIDTH-1:0] x_b;
    logic signed [COORD_WIDTH-1:0] y_b;
    logic [RAD_W-1:0]              radius;
    logic [NS_W-1:0]               sample_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic       in_bounds;
  } out_item_t;

endpackage

@@ rtl/core/circle_obstacle_collision_check.sv @@
// Top level of the circle obstacle collision checker: obstacle table, scan sequencer.
// Depends on cocc_pkg, cocc_ram (obstacle table) and cocc_div (sample interpolation).
//
//  channel  ports                        transfer rule
//  input    start, busy, in_item         start high and busy low at a clock edge
//  result   out_valid, out_item          one cycle, cannot be held off
//  config   cfg_valid/ready/index/data   valid and ready both high
//
// Clear and add go straight to the result state, as does a query that has nothing to
// scan. A point query reads the table RAM one entry a cycle; each entry then passes the
// registered read, a squared distance stage and a compare stage. A segment query runs
// two interpolation divisions per sample, then the scan; it stops after the first
// sample that hits.
// Reset (rst_n, synchronous) empties the table; no clearing pass runs. The receiver
// cannot stall results.
module circle_obstacle_collision_check
  import cocc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_item,
  output logic            out_valid,
  output out_item_t       out_item,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int NW = DIFF_W + NS_W;
  localparam int SQ_W = 2 * DIFF_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIVX, S_DIVY, S_SCAN, S_DRAIN, S_DONE
  } state_t;

  state_t state_r;
  in_item_t item_r;
  logic signed [COORD_WIDTH-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic [NS_W-1:0] samp_r;
  logic signed [COORD_WIDTH+1:0] px_r, py_r;
  logic hit_r;
  logic [1:0] status_r;
  logic inb_r;

  // Pipeline of the scan: read issued, read data valid, squared stage valid.
  logic rd_req_r, rd_v_r, sq_v_r;
  logic [SQ_W:0] dist_r;
  logic [2*RAD_W-1:0] rsq_r;

  logic [ENTRY_W-1:0] rd_data;
  logic wr_en;
  logic div_go, div_done;
  logic signed [NW-1:0] div_num, quo;
  logic signed [DIFF_W-1:0] dx, dy, ex, ey;
  logic signed [COORD_WIDTH-1:0] ent_x, ent_y;
  logic [RAD_W-1:0] ent_r;
  logic [DIFF_W+1:0] mx, my;
  logic scan_last;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign wr_en     = start && !busy && in_item.action == ACT_ADD
                     && count_r < CNT_W'(MAX_OBSTACLES);

  cocc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_OBSTACLES)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({in_item.x_a, in_item.y_a, in_item.radius}),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Interpolation: delta times sample index, then divide by n - 1.
  assign dx = DIFF_W'(item_r.x_b) - DIFF_W'(item_r.x_a);
  assign dy = DIFF_W'(item_r.y_b) - DIFF_W'(item_r.y_a);
  always_comb begin
    if (state_r == S_DIVY || (state_r == S_SCAN)) begin
      div_num = NW'(dy) * $signed({1'b0, samp_r});
    end else begin
      div_num = NW'(dx) * $signed({1'b0, samp_r});
    end
  end

  cocc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (item_r.sample_count - 1'b1),
    .done  (div_done),
    .quo   (quo)
  );

  // Squared distance of the current point to the entry just read.
  assign {ent_x, ent_y, ent_r} = rd_data;
  assign ex = DIFF_W'(px_r) - DIFF_W'(ent_x);
  assign ey = DIFF_W'(py_r) - DIFF_W'(ent_y);
  assign mx = ex[DIFF_W-1] ? (DIFF_W+2)'(-ex) : (DIFF_W+2)'(ex);
  assign my = ey[DIFF_W-1] ? (DIFF_W+2)'(-ey) : (DIFF_W+2)'(ey);
  assign scan_last = (rd_idx_r + 1'b1 >= count_r);

  // Sequencer, configuration registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
      rd_req_r  <= 1'b0;
      rd_v_r    <= 1'b0;
      sq_v_r    <= 1'b0;
      div_go    <= 1'b0;
      x_min_r   <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
      x_max_r   <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
      y_min_r   <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
      y_max_r   <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      out_valid <= 1'b0;
      div_go    <= 1'b0;
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_X_MIN: x_min_r <= cfg_data;
          REG_X_MAX: x_max_r <= cfg_data;
          REG_Y_MIN: y_min_r <= cfg_data;
          REG_Y_MAX: y_max_r <= cfg_data;
          default: ;
        endcase
      end
      rd_req_r <= 1'b0;
      rd_v_r   <= rd_req_r;
      sq_v_r   <= rd_v_r;
      if (rd_v_r) begin
        dist_r <= (SQ_W+1)'(mx * mx) + (SQ_W+1)'(my * my);
        rsq_r  <= ent_r * ent_r;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r   <= in_item;
            status_r <= ST_OK;
            hit_r    <= 1'b0;
            inb_r    <= 1'b0;
            samp_r   <= '0;
            rd_idx_r <= '0;
            px_r     <= (COORD_WIDTH+2)'(in_item.x_a);
            py_r     <= (COORD_WIDTH+2)'(in_item.y_a);
            unique case (action_t'(in_item.action))
              ACT_CLEAR: begin
                count_r <= '0;
                state_r <= S_DONE;
              end
              ACT_ADD: begin
                if (count_r < CNT_W'(MAX_OBSTACLES)) count_r <= count_r + 1'b1;
                else status_r <= ST_FULL;
                state_r <= S_DONE;
              end
              ACT_POINT: begin
                inb_r <= in_item.x_a >= x_min_r && in_item.x_a <= x_max_r
                      && in_item.y_a >= y_min_r && in_item.y_a <= y_max_r;
                if (count_r == '0) state_r <= S_DONE;
                else begin
                  rd_req_r <= 1'b1;
                  state_r  <= S_SCAN;
                end
              end
              default: begin
                if (in_item.sample_count < NS_W'(2)) begin
                  status_r <= ST_FEW;
                  state_r  <= S_DONE;
                end else if (count_r == '0) begin
                  state_r <= S_DONE;
                end else begin
                  div_go  <= 1'b1;
                  state_r <= S_DIVX;
                end
              end
            endcase
          end
        end
        S_DIVX: begin
          if (div_done) begin
            px_r    <= (COORD_WIDTH+2)'(item_r.x_a) + (COORD_WIDTH+2)'(quo);
            div_go  <= 1'b1;
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            py_r     <= (COORD_WIDTH+2)'(item_r.y_a) + (COORD_WIDTH+2)'(quo);
            rd_idx_r <= '0;
            rd_req_r <= 1'b1;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // The read of rd_idx_r is issued here; its data arrives in the next cycle.
          if (scan_last) state_r <= S_DRAIN;
          else begin
            rd_idx_r <= rd_idx_r + 1'b1;
            rd_req_r <= 1'b1;
          end
          if (sq_v_r && dist_r <= (SQ_W+1)'(rsq_r)) hit_r <= 1'b1;
        end
        S_DRAIN: begin
          // Entries still in the pipeline are compared until the last one leaves it.
          if (sq_v_r && rd_v_r) begin
            if (dist_r <= (SQ_W+1)'(rsq_r)) hit_r <= 1'b1;
          end else if (sq_v_r) begin
            if (dist_r <= (SQ_W+1)'(rsq_r) || hit_r) begin
              hit_r   <= 1'b1;
              state_r <= S_DONE;
            end else if (item_r.action == ACT_SEG
                         && samp_r != item_r.sample_count - 1'b1) begin
              samp_r  <= samp_r + 1'b1;
              div_go  <= 1'b1;
              state_r <= S_DIVX;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_item  <= '{status: status_r, hit: hit_r, in_bounds: inb_r};
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Assertions on the sequencer and table.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_OBSTACLES)) else $error("obstacle count overflow");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two results back to back");
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid && !busy) else $error("result lost");
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |-> !out_item.hit) else $error("bad add result");

endmodule

@@ rtl/core/cocc_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies.
module cocc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/cocc_div.sv @@
// Restoring divider, one quotient bit a cycle, sign fixed at the end (truncating).
// Depends on cocc_pkg for the difference and sample count widths.
module cocc_div
  import cocc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic signed [DIFF_W+NS_W-1:0] num,
  input  logic [NS_W-1:0]         den,
  output logic                    done,
  output logic signed [DIFF_W+NS_W-1:0] quo
);

  localparam int NW = DIFF_W + NS_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]   mag_r;
  logic [NW-1:0]   q_r;
  logic [NS_W-1:0] rem_r;
  logic [NS_W-1:0] den_r;
  logic            neg_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic [NS_W:0]   trial;
  logic [NS_W:0]   shifted;

  always_comb begin
    shifted = {rem_r, mag_r[NW-1]};
    trial   = shifted - {1'b0, den_r};
  end

  // One quotient bit per cycle; the magnitude shifts out its top bit each step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        neg_r  <= num[NW-1];
        mag_r  <= num[NW-1] ? NW'(-num) : NW'(num);
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        mag_r <= {mag_r[NW-2:0], 1'b0};
        if (!trial[NS_W]) begin
          rem_r <= trial[NS_W-1:0];
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= shifted[NS_W-1:0];
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

@@ test/circle_obstacle_collision_check_tb.sv @@
// Testbench for circle_obstacle_collision_check: directed table then random items.
// Depends on cocc_pkg and the top level; predicts results with its own obstacle table.
`timescale 1ns / 1ps

module circle_obstacle_collision_check_tb;
  import cocc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000000;
  localparam int TAIL_CYCLES    = 200;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [COORD_WIDTH-1:0] cfg_data;

  circle_obstacle_collision_check u_top (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: obstacle table and workspace bounds.
  logic signed [COORD_WIDTH-1:0] obs_x [MAX_OBSTACLES];
  logic signed [COORD_WIDTH-1:0] obs_y [MAX_OBSTACLES];
  logic [RAD_W-1:0]              obs_r [MAX_OBSTACLES];
  int                            obs_count;
  logic signed [COORD_WIDTH-1:0] bound_x_min, bound_x_max, bound_y_min, bound_y_max;

  out_item_t pending_results[$];
  int        mismatches;
  int        results_seen;
  int        idle_cycles;
  int        hits_seen;

  // Directed stimulus rows; fixed marks rows whose expected result is typed in.
  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } dir_row_t;

  dir_row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Squared distance test against every stored obstacle; 64-bit is ample.
  function automatic bit point_in_obstacle(input longint px, input longint py);
    longint dx, dy;
    longint unsigned dist2, r2;
    for (int k = 0; k < obs_count; k++) begin
      dx = px - longint'(obs_x[k]);
      dy = py - longint'(obs_y[k]);
      dist2 = dx * dx + dy * dy;
      r2 = longint'(obs_r[k]) * longint'(obs_r[k]);
      if (dist2 <= r2) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the result of one item and updates the obstacle table.
  function automatic out_item_t collision_predict(input in_item_t it);
    out_item_t res;
    longint ax, ay, ddx, ddy, div;
    res = '0;
    ax = longint'(it.x_a);
    ay = longint'(it.y_a);
    case (action_t'(it.action))
      ACT_CLEAR: obs_count = 0;
      ACT_ADD: begin
        if (obs_count >= MAX_OBSTACLES) begin
          res.status = ST_FULL;
        end else begin
          obs_x[obs_count] = it.x_a;
          obs_y[obs_count] = it.y_a;
          obs_r[obs_count] = it.radius;
          obs_count++;
        end
      end
      ACT_POINT: begin
        res.hit = point_in_obstacle(ax, ay);
        res.in_bounds = (it.x_a >= bound_x_min) && (it.x_a <= bound_x_max) &&
                        (it.y_a >= bound_y_min) && (it.y_a <= bound_y_max);
      end
      default: begin
        if (it.sample_count < 2) begin
          res.status = ST_FEW;
        end else begin
          ddx = longint'(it.x_b) - ax;
          ddy = longint'(it.y_b) - ay;
          div = longint'(it.sample_count) - 1;
          for (int i = 0; i < it.sample_count; i++) begin
            // SystemVerilog division truncates toward zero, as required.
            if (point_in_obstacle(ax + (ddx * i) / div, ay + (ddy * i) / div)) begin
              res.hit = 1'b1;
              break;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // Result checking: each strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (out_item.hit) hits_seen <= hits_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result: status %0d hit %0b in_bounds %0b",
                   out_item.status, out_item.hit, out_item.in_bounds);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status || out_item.hit !== want.hit ||
            out_item.in_bounds !== want.in_bounds) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d hit %0b in_bounds %0b, got %0d %0b %0b",
                     want.status, want.hit, want.in_bounds,
                     out_item.status, out_item.hit, out_item.in_bounds);
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  int burst_left;

  // One item transfer, with the bursty sender pattern ahead of it. Start stays high
  // between items of a burst and is dropped only for a gap or when the sender stops.
  task automatic send_item(input in_item_t it, input bit check_fixed, input out_item_t fixed);
    out_item_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = collision_predict(it);
    if (check_fixed && pred != fixed) begin
      mismatches = mismatches + 1;
      if (mismatches <= 10)
        $display("directed row disagrees with prediction: action %0d", it.action);
    end
    pending_results.insert(pending_results.size(), check_fixed ? fixed : pred);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Holds valid high until the write transfers; the caller drops it afterwards.
  task automatic write_reg(input reg_idx_t idx, input logic [COORD_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_MIN: bound_x_min = val;
      REG_X_MAX: bound_x_max = val;
      REG_Y_MIN: bound_y_min = val;
      default:   bound_y_max = val;
    endcase
  endtask

  function automatic in_item_t make_item(input action_t act, input int xa, input int ya,
                                         input int xb, input int yb, input int rad,
                                         input int cnt);
    in_item_t it;
    it.action = act;
    it.x_a = COORD_WIDTH'(xa); it.y_a = COORD_WIDTH'(ya);
    it.x_b = COORD_WIDTH'(xb); it.y_b = COORD_WIDTH'(yb);
    it.radius = RAD_W'(rad);
    it.sample_count = NS_W'(cnt);
    return it;
  endfunction

  function automatic void add_row(input in_item_t item, input bit fixed,
                                  input out_item_t want);
    dir_row_t row;
    row.item  = item;
    row.fixed = fixed;
    row.want  = want;
    rows.insert(rows.size(), row);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return COORD_WIDTH'($urandom());
  endfunction

  initial begin
    in_item_t it;
    int n_items, phase;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_X_MIN;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    hits_seen = 0;
    idle_cycles = 0;
    burst_left = 0;
    obs_count = 0;
    bound_x_min = 16'sh8000; bound_x_max = 16'sh7FFF;
    bound_y_min = 16'sh8000; bound_y_max = 16'sh7FFF;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: empty table, extremes, too few samples, full table.
    add_row(make_item(ACT_POINT, 0, 0, 0, 0, 0, 0), 1'b1, '{ST_OK, 1'b0, 1'b1});
    add_row(make_item(ACT_POINT, -32768, 32767, 0, 0, 0, 0), 1'b1, '{ST_OK, 1'b0, 1'b1});
    add_row(make_item(ACT_SEG, 0, 0, 5, 5, 0, 0), 1'b1, '{ST_FEW, 1'b0, 1'b0});
    add_row(make_item(ACT_SEG, 0, 0, 5, 5, 0, 1), 1'b1, '{ST_FEW, 1'b0, 1'b0});
    add_row(make_item(ACT_ADD, 0, 0, 0, 0, 0, 0), 1'b1, '{ST_OK, 1'b0, 1'b0});
    add_row(make_item(ACT_POINT, 0, 0, 0, 0, 0, 0), 1'b1, '{ST_OK, 1'b1, 1'b1});
    add_row(make_item(ACT_POINT, 1, 0, 0, 0, 0, 0), 1'b1, '{ST_OK, 1'b0, 1'b1});
    add_row(make_item(ACT_ADD, 32767, 32767, 0, 0, 32767, 0), 1'b0, '0);
    add_row(make_item(ACT_POINT, -32768, -32768, 0, 0, 0, 0), 1'b0, '0);
    add_row(make_item(ACT_SEG, -32768, -32768, 32767, 32767, 0, 4095), 1'b0, '0);
    add_row(make_item(ACT_SEG, -100, 3, 100, -3, 0, 2), 1'b0, '0);
    add_row(make_item(ACT_SEG, 7, -9, -7, 9, 0, 3), 1'b0, '0);
    add_row(make_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0), 1'b1, '{ST_OK, 1'b0, 1'b0});
    add_row(make_item(ACT_POINT, 0, 0, 0, 0, 0, 0), 1'b1, '{ST_OK, 1'b0, 1'b1});
    foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].want);
    // Fill the table, then one add too many.
    for (int k = 0; k < MAX_OBSTACLES; k++)
      send_item(make_item(ACT_ADD, k * 300 - 9000, k * 200, 0, 0, k * 8 + 1, 0), 0, '0);
    send_item(make_item(ACT_ADD, 1, 1, 1, 1, 1, 0), 1, '{ST_FULL, 1'b0, 1'b0});
    send_item(make_item(ACT_SEG, -9000, 0, 10000, 12600, 0, 40), 0, '0);
    send_item(make_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0), 1, '{ST_OK, 1'b0, 1'b0});
    wait_drained();

    // Random phases, each under its own bound setting.
    n_items = 0;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_X_MIN, 16'h8000); write_reg(REG_X_MAX, 16'h7FFF);
          write_reg(REG_Y_MIN, 16'h8000); write_reg(REG_Y_MAX, 16'h7FFF);
        end
        1: begin
          write_reg(REG_X_MIN, 16'h7FFF); write_reg(REG_X_MAX, 16'h8000);
          write_reg(REG_Y_MIN, 16'h0000); write_reg(REG_Y_MAX, 16'h0000);
        end
        default: begin
          write_reg(REG_X_MIN, COORD_WIDTH'($urandom_range(0, 65535) | 16'h8000));
          write_reg(REG_X_MAX, COORD_WIDTH'($urandom_range(0, 32767)));
          write_reg(REG_Y_MIN, COORD_WIDTH'($urandom()));
          write_reg(REG_Y_MAX, COORD_WIDTH'($urandom()));
        end
      endcase
      cfg_valid <= 1'b0;
      repeat (94) begin
        int pick;
        int cx, cy;
        pick = $urandom_range(0, 99);
        cx = $urandom_range(0, 4000) - 2000;
        cy = $urandom_range(0, 4000) - 2000;
        if (pick < 4) begin
          it = make_item(ACT_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom());
        end else if (pick < 40) begin
          it = make_item(ACT_ADD, cx, cy, $urandom(), $urandom(),
                         $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 800),
                         $urandom());
        end else if (pick < 75) begin
          it = make_item(ACT_POINT, $urandom_range(0, 3) == 0 ? rand_coord() : cx,
                         $urandom_range(0, 3) == 0 ? rand_coord() : cy,
                         $urandom(), $urandom(), $urandom(), $urandom());
        end else begin
          it = make_item(ACT_SEG, $urandom_range(0, 4) == 0 ? rand_coord() : cx,
                         $urandom_range(0, 4) == 0 ? rand_coord() : cy,
                         $urandom_range(0, 4) == 0 ? rand_coord() : -cx,
                         $urandom_range(0, 4) == 0 ? rand_coord() : -cy,
                         $urandom(),
                         $urandom_range(0, 30) == 0 ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 12));
        end
        send_item(it, 0, '0);
        n_items++;
      end
      wait_drained();
    end

    $display("Covered %0d directed and %0d random items, %0d results, %0d hits,",
             rows.size() + MAX_OBSTACLES + 3, n_items, results_seen, hits_seen);
    $display("five bound settings including full range and crossed bounds.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
